// ----- rtl/ces_pkg.sv -----
// Package for the cyclic-executive scheduler.
// Holds the item and result payload types, opcodes, report kinds, task states
// and the sequencer state type. It has no dependencies.
package ces_pkg;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] task_index;
		logic [3:0] frame_number;
		logic [2:0] slot_number;
		logic       slot_used;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] task_number;
		logic [2:0] priority_rank;
		logic [3:0] frame_now;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       used;
		logic [3:0] id;
	} ft_entry_t;

	typedef struct packed {
		logic       miss;
		logic [1:0] status;
	} st_entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_EV_WB,
		S_CLOSE,
		S_CLOSE_DRAIN,
		S_AP_RD,
		S_AP_WB,
		S_REL,
		S_REL_DRAIN
	} state_t;

	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_DONE  = 3'd3;
	localparam logic [2:0] OP_AP    = 3'd4;

	localparam logic [2:0] KIND_RELEASED   = 3'd0;
	localparam logic [2:0] KIND_AP_ACCEPT  = 3'd1;
	localparam logic [2:0] KIND_AP_REJECT  = 3'd2;
	localparam logic [2:0] KIND_MISS_CANCEL = 3'd3;
	localparam logic [2:0] KIND_MISS_RUN   = 3'd4;
	localparam logic [2:0] KIND_RECOVERED  = 3'd5;
	localparam logic [2:0] KIND_FRAME_DONE = 3'd6;
	localparam logic [2:0] KIND_ACK        = 3'd7;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_PENDING = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_TASKS  = 1'b1;

	localparam logic [3:0] AP_ID   = 4'd15;
	localparam logic [2:0] RANK_MAX = 3'd7;

endpackage

// ----- rtl/cyclic_executive_scheduler_top.sv -----
// Top level of the cyclic-executive scheduler.
// Holds the frame table and task state memories and the sequencer that walks them.
// Depends on ces_pkg.
//
// After reset the block sweeps both memories clear, one entry a cycle, with
// busy high. A start or done of a valid task reads the task state memory in
// S_IDLE and writes it back in S_EV_WB; a load slot, aperiodic request,
// unknown command, or start or done with an ignored task id is handled in
// S_IDLE alone. A frame tick walks the frame table one slot a cycle through
// a three-stage read pipeline for the closing frame and again for the new
// one, with an S_AP_WB step between the walks when an aperiodic request is
// pending. The first tick after reset has no closing walk.
// Each result is shown for one cycle with result_valid
// and must be taken then; the receiver cannot stall the block.
module cyclic_executive_scheduler_top
	import ces_pkg::*;
#(
	parameter int MAX_TASKS       = 15,
	parameter int MAX_FRAMES      = 16,
	parameter int SLOTS_PER_FRAME = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        result_valid,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int FT_N  = MAX_FRAMES * SLOTS_PER_FRAME;
	localparam int ST_N  = MAX_TASKS + 1;
	localparam int CLR_N = (FT_N > ST_N) ? FT_N : ST_N;
	localparam int AW    = (FT_N > 1) ? $clog2(FT_N) : 1;
	localparam int TW    = $clog2(ST_N);
	localparam int CLRW  = $clog2(CLR_N);
	localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int SW    = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;

	ft_entry_t ft_mem [FT_N];
	st_entry_t st_mem [ST_N];

	state_t          state_q, state_d;
	logic [CLRW-1:0] clr_q;
	logic [SW-1:0]   slot_q;
	logic [2:0]      rank_q;
	logic [FW-1:0]   cur_q;
	logic            started_q;
	logic            ap_pend_q;
	logic [4:0]      frames_q;
	logic [3:0]      tasks_q;

	logic            v_s1, mode_s1, v_s2, mode_s2;
	logic [3:0]      id_s2;
	logic            ev_done_q;
	logic [3:0]      ev_task_q;

	ft_entry_t       ft_rdata_q, ft_wdata;
	logic [AW-1:0]   ft_raddr, ft_waddr;
	logic            ft_we;

	st_entry_t       st_rdata_q, st_wdata, st_eff, fwd_data_q;
	logic [TW-1:0]   st_raddr, st_waddr, rd_idx_q, fwd_idx_q, ev_idx;
	logic            st_we, fwd_v_q;

	logic            emit_v, emit_last;
	logic [2:0]      emit_kind, emit_rank;
	logic [3:0]      emit_task;
	logic            adv, rank_inc, walk_issue, slot_last, pipe_empty;
	logic            in_periodic_ok, ev_slot_ok, wrap;
	logic [4:0]      lim;

	logic            result_valid_q;
	result_t         result_q;

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign walk_issue = (state_q == S_CLOSE) || (state_q == S_REL);
	assign slot_last  = (int'(slot_q) == SLOTS_PER_FRAME - 1);
	assign pipe_empty = !v_s1 && !v_s2;
	assign st_eff     = (fwd_v_q && fwd_idx_q == rd_idx_q) ? fwd_data_q : st_rdata_q;

	assign in_periodic_ok = (item.task_index != AP_ID) && (item.task_index < tasks_q)
		&& (int'(item.task_index) < MAX_TASKS);
	assign ev_slot_ok = (item.task_index == AP_ID) || in_periodic_ok;
	assign ev_idx     = (item.task_index == AP_ID) ? TW'(MAX_TASKS) : TW'(item.task_index);

	assign lim  = (frames_q == 5'd0) ? 5'd1 :
		((int'(frames_q) > MAX_FRAMES) ? 5'(MAX_FRAMES) : frames_q);
	assign wrap = (int'(cur_q) + 1 >= int'(lim));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (int'(clr_q) == CLR_N - 1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					case (item.opcode)
						OP_TICK:  state_d = started_q ? S_CLOSE : S_AP_RD;
						OP_START: state_d = ev_slot_ok ? S_EV_WB : S_IDLE;
						OP_DONE:  state_d = ev_slot_ok ? S_EV_WB : S_IDLE;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_EV_WB:       state_d = S_IDLE;
			S_CLOSE:       state_d = slot_last ? S_CLOSE_DRAIN : S_CLOSE;
			S_CLOSE_DRAIN: state_d = pipe_empty ? S_AP_RD : S_CLOSE_DRAIN;
			S_AP_RD:       state_d = ap_pend_q ? S_AP_WB : S_REL;
			S_AP_WB:       state_d = S_REL;
			S_REL:         state_d = slot_last ? S_REL_DRAIN : S_REL;
			S_REL_DRAIN:   state_d = pipe_empty ? S_IDLE : S_REL_DRAIN;
			default:       state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ft_we     = 1'b0;
		ft_waddr  = '0;
		ft_wdata  = '0;
		ft_raddr  = AW'(int'(cur_q) * SLOTS_PER_FRAME + int'(slot_q));
		st_we     = 1'b0;
		st_waddr  = rd_idx_q;
		st_wdata  = '0;
		st_raddr  = TW'(ft_rdata_q.id);
		emit_v    = 1'b0;
		emit_kind = KIND_ACK;
		emit_task = '0;
		emit_rank = '0;
		emit_last = 1'b0;
		adv       = 1'b0;
		rank_inc  = 1'b0;

		if (v_s2) begin
			emit_task = id_s2;
			if (!mode_s2) begin
				if (st_eff.status == ST_PENDING) begin
					st_we     = 1'b1;
					st_wdata  = '{miss: st_eff.miss, status: ST_IDLE};
					emit_v    = 1'b1;
					emit_kind = KIND_MISS_CANCEL;
				end else if (st_eff.status == ST_RUNNING && !st_eff.miss) begin
					st_we     = 1'b1;
					st_wdata  = '{miss: 1'b1, status: ST_RUNNING};
					emit_v    = 1'b1;
					emit_kind = KIND_MISS_RUN;
				end
			end else if (st_eff.status == ST_IDLE) begin
				st_we     = 1'b1;
				st_wdata  = '{miss: st_eff.miss, status: ST_PENDING};
				emit_v    = 1'b1;
				emit_kind = KIND_RELEASED;
				emit_rank = rank_q;
				rank_inc  = (rank_q != RANK_MAX);
			end
		end

		case (state_q)
			S_CLEAR: begin
				ft_we    = (int'(clr_q) < FT_N);
				ft_waddr = clr_q[AW-1:0];
				st_we    = (int'(clr_q) < ST_N);
				st_waddr = clr_q[TW-1:0];
			end
			S_IDLE: begin
				st_raddr = ev_idx;
				if (start) begin
					emit_task = item.task_index;
					emit_last = 1'b1;
					case (item.opcode)
						OP_LOAD: begin
							emit_v   = 1'b1;
							ft_waddr = AW'(int'(item.frame_number) * SLOTS_PER_FRAME
								+ int'(item.slot_number));
							ft_wdata = item.slot_used ?
								ft_entry_t'{used: 1'b1, id: item.task_index} : '0;
							ft_we    = (int'(item.frame_number) < MAX_FRAMES)
								&& (int'(item.slot_number) < SLOTS_PER_FRAME)
								&& (!item.slot_used || in_periodic_ok);
						end
						OP_TICK:  emit_v = 1'b0;
						OP_START: emit_v = !ev_slot_ok;
						OP_DONE:  emit_v = !ev_slot_ok;
						default:  emit_v = 1'b1;
					endcase
				end
			end
			S_EV_WB: begin
				emit_v    = 1'b1;
				emit_task = ev_task_q;
				emit_last = 1'b1;
				if (!ev_done_q) begin
					if (st_eff.status == ST_PENDING) begin
						st_we    = 1'b1;
						st_wdata = '{miss: st_eff.miss, status: ST_RUNNING};
					end
				end else if (st_eff.status == ST_RUNNING) begin
					st_we    = 1'b1;
					st_wdata = '{miss: 1'b0, status: ST_IDLE};
					if (st_eff.miss) emit_kind = KIND_RECOVERED;
				end
			end
			S_CLOSE_DRAIN: begin
				adv = pipe_empty;
			end
			S_AP_RD: begin
				st_raddr = TW'(MAX_TASKS);
			end
			S_AP_WB: begin
				emit_v    = 1'b1;
				emit_task = AP_ID;
				if (st_eff.status == ST_IDLE) begin
					st_we     = 1'b1;
					st_wdata  = '{miss: st_eff.miss, status: ST_PENDING};
					emit_kind = KIND_AP_ACCEPT;
				end else begin
					emit_kind = KIND_AP_REJECT;
				end
			end
			S_REL_DRAIN: begin
				if (pipe_empty) begin
					emit_v    = 1'b1;
					emit_kind = KIND_FRAME_DONE;
					emit_last = 1'b1;
				end
			end
			default: begin
				adv = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			slot_q         <= '0;
			rank_q         <= '0;
			cur_q          <= '0;
			started_q      <= 1'b0;
			ap_pend_q      <= 1'b0;
			frames_q       <= 5'd1;
			tasks_q        <= 4'd15;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			fwd_v_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit_v;
			v_s1           <= walk_issue;
			v_s2           <= v_s1 && ft_rdata_q.used;
			fwd_v_q        <= st_we;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (walk_issue && !slot_last) slot_q <= slot_q + 1'b1;
			else slot_q <= '0;
			if (state_q == S_IDLE && start) begin
				if (item.opcode == OP_TICK) begin
					started_q <= 1'b1;
					rank_q    <= '0;
				end
				if (item.opcode == OP_AP) ap_pend_q <= 1'b1;
			end
			if (rank_inc) rank_q <= rank_q + 1'b1;
			if (state_q == S_AP_WB) ap_pend_q <= 1'b0;
			if (adv) cur_q <= wrap ? '0 : cur_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == CFG_FRAMES) frames_q <= cfg_data;
				else tasks_q <= cfg_data[3:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s1    <= (state_q == S_REL);
		mode_s2    <= mode_s1;
		id_s2      <= ft_rdata_q.id;
		rd_idx_q   <= st_raddr;
		fwd_idx_q  <= st_waddr;
		fwd_data_q <= st_wdata;
		if (state_q == S_IDLE) begin
			ev_done_q <= (item.opcode == OP_DONE);
			ev_task_q <= item.task_index;
		end
		result_q.kind          <= emit_kind;
		result_q.task_number   <= emit_task;
		result_q.priority_rank <= emit_rank;
		result_q.frame_now     <= 4'(cur_q);
		result_q.last          <= emit_last;
	end

	always_ff @(posedge clk) begin
		if (ft_we) ft_mem[ft_waddr] <= ft_wdata;
		ft_rdata_q <= ft_mem[ft_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_waddr] <= st_wdata;
		st_rdata_q <= st_mem[st_raddr];
	end

endmodule
